// File: rtl/bsfd_pkg.sv
// Shared types, constants and register codes of the byte-stuffed frame decoder.
package bsfd_pkg;

   localparam int MAX_FRAME_DEF = 32;
   localparam int BYTE_W        = 8;
   localparam int POS_W         = 5;
   localparam int CSR_INDEX_W   = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_CODE     = 3'd0,
      CSR_END_CODE       = 3'd1,
      CSR_ESCAPE_CODE    = 3'd2,
      CSR_START_ESCAPED  = 3'd3,
      CSR_END_ESCAPED    = 3'd4,
      CSR_ESCAPE_ESCAPED = 3'd5
   } csr_index_type;

   localparam logic [BYTE_W-1:0] START_CODE_RST     = 8'd1;
   localparam logic [BYTE_W-1:0] END_CODE_RST       = 8'd2;
   localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST    = 8'd3;
   localparam logic [BYTE_W-1:0] START_ESCAPED_RST  = 8'd4;
   localparam logic [BYTE_W-1:0] END_ESCAPED_RST    = 8'd5;
   localparam logic [BYTE_W-1:0] ESCAPE_ESCAPED_RST = 8'd6;

   typedef struct packed {
      logic [BYTE_W-1:0] start_code;
      logic [BYTE_W-1:0] end_code;
      logic [BYTE_W-1:0] escape_code;
      logic [BYTE_W-1:0] start_escaped;
      logic [BYTE_W-1:0] end_escaped;
      logic [BYTE_W-1:0] escape_escaped;
   } cfg_type;

endpackage

// File: rtl/bsfd_frame_mem.sv
// Frame store: synchronous RAM, one write port, one read port with registered data.
module bsfd_frame_mem
   import bsfd_pkg::*;
#(
   parameter int DEPTH = MAX_FRAME_DEF,
   parameter int AW    = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bsfd_decode.sv
// Unstuffing state machine, frame store writes and frame read-out with output register.
module bsfd_decode
   import bsfd_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_frame_byte,
   output logic [POS_W-1:0]  rsp_byte_position,
   output logic              rsp_last_of_frame
);

   localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
   localparam int CW = $clog2(MAX_FRAME + 1);
   localparam logic [CW-1:0] FULL = CW'(MAX_FRAME);

   typedef enum logic {ST_IDLE, ST_READ} state_type;

   state_type         state_ff, state_in;
   logic              in_frame_ff, in_frame_in;
   logic              esc_ff, esc_in;
   logic [CW-1:0]     fill_ff, fill_in;
   logic [CW-1:0]     len_ff, len_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     pend_pos_ff, pend_pos_in;
   logic              pend_last_ff, pend_last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              wr_en;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [BYTE_W-1:0] rd_data;
   logic              move;

   bsfd_frame_mem #(
      .DEPTH (MAX_FRAME),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign move      = pend_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      in_frame_in  = in_frame_ff;
      esc_in       = esc_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = pend_ff;
      pend_pos_in  = pend_pos_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_data      = req_rx_byte;
      rd_en        = 1'b0;

      // unstuffing; writes happen only while idle, reads only in read-out
      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == cfg.start_code) begin
               in_frame_in = 1'b1;
               esc_in      = 1'b0;
               fill_in     = '0;
            end
         end else if (req_rx_byte == cfg.end_code && !esc_ff) begin
            if (fill_ff != '0) begin
               state_in  = ST_READ;
               len_in    = fill_ff;
               rd_idx_in = '0;
            end
            in_frame_in = 1'b0;
            esc_in      = 1'b0;
            fill_in     = '0;
         end else if (req_rx_byte == cfg.start_code) begin
            fill_in = '0;
            esc_in  = 1'b0;
         end else if (fill_ff == FULL) begin
            in_frame_in = 1'b0;
            esc_in      = 1'b0;
            fill_in     = '0;
         end else if (req_rx_byte == cfg.escape_code && !esc_ff) begin
            esc_in = 1'b1;
         end else if (esc_ff) begin
            esc_in = 1'b0;
            if (req_rx_byte == cfg.start_escaped) begin
               wr_en   = 1'b1;
               wr_data = cfg.start_code;
            end else if (req_rx_byte == cfg.escape_escaped) begin
               wr_en   = 1'b1;
               wr_data = cfg.escape_code;
            end else if (req_rx_byte == cfg.end_escaped) begin
               wr_en   = 1'b1;
               wr_data = cfg.end_code;
            end else begin
               in_frame_in = 1'b0;
               fill_in     = '0;
            end
         end else begin
            wr_en = 1'b1;
         end
         if (wr_en) begin
            fill_in = CW'(fill_ff + 1'b1);
         end
      end

      // output register drains independently
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = rd_data;
         rsp_pos_in   = POS_W'(pend_pos_ff);
         rsp_last_in  = pend_last_ff;
         pend_in      = 1'b0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // read-out: issue a read when the pending slot frees up
      if (state_ff == ST_READ) begin
         if (rd_idx_ff != len_ff) begin
            if (!pend_ff || move) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_pos_in  = rd_idx_ff;
               pend_last_in = (CW'(rd_idx_ff + 1'b1) == len_ff);
               rd_idx_in    = CW'(rd_idx_ff + 1'b1);
            end
         end else if (!pend_ff || move) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_frame_ff  <= 1'b0;
         esc_ff       <= 1'b0;
         fill_ff      <= '0;
         len_ff       <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_frame_ff  <= in_frame_in;
         esc_ff       <= esc_in;
         fill_ff      <= fill_in;
         len_ff       <= len_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_pos_ff  <= pend_pos_in;
      pend_last_ff <= pend_last_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_byte    = rsp_byte_ff;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

// File: rtl/byte_stuffed_frame_decoder.sv
// Top level: configuration registers, decoder with frame store, and port checks.
// Input: one raw byte is taken per cycle while idle; req stalls for the whole read-out.
// Output: after an end code closes a non-empty frame, the state register, the read
//   register of the frame store's single read port with its pending slot, and the output
//   register lie before the first result; one per cycle follows while rsp_stall is low.
// Reset: control state clears, codes return to 1..6; the frame store is not cleared.
module byte_stuffed_frame_decoder
   import bsfd_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [BYTE_W-1:0]      rsp_frame_byte,
   output logic [POS_W-1:0]       rsp_byte_position,
   output logic                   rsp_last_of_frame,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_data
);

   cfg_type cfg_ff;

   // register writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code     <= START_CODE_RST;
         cfg_ff.end_code       <= END_CODE_RST;
         cfg_ff.escape_code    <= ESCAPE_CODE_RST;
         cfg_ff.start_escaped  <= START_ESCAPED_RST;
         cfg_ff.end_escaped    <= END_ESCAPED_RST;
         cfg_ff.escape_escaped <= ESCAPE_ESCAPED_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_CODE:     cfg_ff.start_code     <= csr_data;
            CSR_END_CODE:       cfg_ff.end_code       <= csr_data;
            CSR_ESCAPE_CODE:    cfg_ff.escape_code    <= csr_data;
            CSR_START_ESCAPED:  cfg_ff.start_escaped  <= csr_data;
            CSR_END_ESCAPED:    cfg_ff.end_escaped    <= csr_data;
            CSR_ESCAPE_ESCAPED: cfg_ff.escape_escaped <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // unstuff, store, and replay each closed frame as a run of transactions
   bsfd_decode #(
      .MAX_FRAME (MAX_FRAME)
   ) u_decode (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   // a non-final byte on the output means the rest of the run is still in flight
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_frame |-> req_stall)
      else $error("non-final frame byte shown while input side is open");

   // positions within a run advance by one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_of_frame |=>
         !rsp_valid || rsp_byte_position == POS_W'($past(rsp_byte_position) + 1'b1))
      else $error("byte position did not advance by one");

   // reset leaves the block idle with nothing to deliver
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

endmodule

// File: tb/sv/byte_stuffed_frame_decoder_checker.sv
// Checker for the frame decoder: watches all three channels, predicts decoded bytes, compares.
module byte_stuffed_frame_decoder_checker
   import bsfd_pkg::*;
#(
   parameter int MAX_FRAME = MAX_FRAME_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [BYTE_W-1:0]      req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [BYTE_W-1:0]      rsp_frame_byte,
   input  logic [POS_W-1:0]       rsp_byte_position,
   input  logic                   rsp_last_of_frame,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_data,
   output int                     failures,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic [POS_W-1:0]  pos;
      logic              last;
   } frame_beat_type;

   frame_beat_type    decoded_q [$];
   cfg_type           live_codes;
   logic              framing;
   logic              esc_armed;
   int                fill;
   logic [BYTE_W-1:0] frame_bytes [MAX_FRAME];

   task automatic drop_frame();
      framing   = 1'b0;
      esc_armed = 1'b0;
      fill      = 0;
   endtask

   task automatic keep_byte(input logic [BYTE_W-1:0] b);
      if (fill < MAX_FRAME) begin
         frame_bytes[fill] = b;
         fill++;
      end
   endtask

   // Advance the decoder by one raw byte; a closing end code queues the whole frame.
   task automatic decode_rx_byte(input logic [BYTE_W-1:0] b);
      frame_beat_type beat;
      if (!framing) begin
         if (b == live_codes.start_code) begin
            framing   = 1'b1;
            esc_armed = 1'b0;
            fill      = 0;
         end
      end else if (b == live_codes.end_code && !esc_armed) begin
         for (int k = 0; k < fill; k++) begin
            beat.data = frame_bytes[k];
            beat.pos  = POS_W'(k);
            beat.last = (k + 1 == fill);
            decoded_q.push_back(beat);
         end
         drop_frame();
      end else if (b == live_codes.start_code) begin
         fill      = 0;
         esc_armed = 1'b0;
      end else if (fill >= MAX_FRAME) begin
         drop_frame();
      end else if (b == live_codes.escape_code && !esc_armed) begin
         esc_armed = 1'b1;
      end else if (esc_armed) begin
         esc_armed = 1'b0;
         if (b == live_codes.start_escaped) keep_byte(live_codes.start_code);
         else if (b == live_codes.escape_escaped) keep_byte(live_codes.escape_code);
         else if (b == live_codes.end_escaped) keep_byte(live_codes.end_code);
         else drop_frame();
      end else begin
         keep_byte(b);
      end
   endtask

   always @(posedge clock) begin
      frame_beat_type want;
      if (reset) begin
         live_codes = '{start_code: START_CODE_RST, end_code: END_CODE_RST,
                        escape_code: ESCAPE_CODE_RST, start_escaped: START_ESCAPED_RST,
                        end_escaped: END_ESCAPED_RST, escape_escaped: ESCAPE_ESCAPED_RST};
         drop_frame();
         decoded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (decoded_q.size() == 0) begin
               failures++;
               $display("%0t ns: unexpected result: expected none, actual byte %h pos %0d last %b",
                        $time, rsp_frame_byte, rsp_byte_position, rsp_last_of_frame);
            end else begin
               want = decoded_q.pop_front();
               if (rsp_frame_byte !== want.data) begin
                  failures++;
                  $display("%0t ns: frame_byte mismatch: expected %h, actual %h",
                           $time, want.data, rsp_frame_byte);
               end
               if (rsp_byte_position !== want.pos) begin
                  failures++;
                  $display("%0t ns: byte_position mismatch: expected %0d, actual %0d",
                           $time, want.pos, rsp_byte_position);
               end
               if (rsp_last_of_frame !== want.last) begin
                  failures++;
                  $display("%0t ns: last_of_frame mismatch: expected %b, actual %b",
                           $time, want.last, rsp_last_of_frame);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_CODE:     live_codes.start_code     = csr_data;
               CSR_END_CODE:       live_codes.end_code       = csr_data;
               CSR_ESCAPE_CODE:    live_codes.escape_code    = csr_data;
               CSR_START_ESCAPED:  live_codes.start_escaped  = csr_data;
               CSR_END_ESCAPED:    live_codes.end_escaped    = csr_data;
               CSR_ESCAPE_ESCAPED: live_codes.escape_escaped = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) decode_rx_byte(req_rx_byte);
      end
      outstanding = decoded_q.size();
   end

endmodule

// File: tb/sv/byte_stuffed_frame_decoder_tb.sv
// Testbench top: clock, reset, framed byte stimulus, result back-pressure and the verdict.
module byte_stuffed_frame_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bsfd_pkg::*;

   localparam int LONG_HOLD    = 200;        // cycles of the long receiver hold-off
   localparam int RUN_LIMIT_NS = 2_000_000;  // far beyond the slowest correct run

   // Register indexes past the defined set; the block must ignore writes to them.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   // Every input of the block starts at a known value.
   logic                   clock             = 1'b0;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_rx_byte       = '0;
   logic                   rsp_valid;
   logic                   rsp_stall         = 1'b0;
   logic [BYTE_W-1:0]      rsp_frame_byte;
   logic [POS_W-1:0]       rsp_byte_position;
   logic                   rsp_last_of_frame;
   logic                   csr_valid         = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index         = '0;
   logic [BYTE_W-1:0]      csr_data          = '0;

   int   chk_failures;
   int   chk_outstanding;

   // Control shared by the stimulus, the receiver and the hold-off process.
   bit   quiet       = 1'b0;  // no idling on either side
   bit   hold_go     = 1'b0;  // request the long receiver hold-off
   bit   hold_active = 1'b0;

   cfg_type           codes;          // codes the encoder uses, tracks every register write
   logic [BYTE_W-1:0] wire_q [$];     // raw bytes waiting to go onto the link
   int                framed_items;   // raw bytes sent inside frames in the current phase

   byte_stuffed_frame_decoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   byte_stuffed_frame_decoder_checker chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .failures          (chk_failures),
      .outstanding       (chk_outstanding)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #RUN_LIMIT_NS;
      $display("TB_ERROR");
      $finish;
   end

   // Long hold-off: once requested, stall the result side for the LONG_HOLD period so the
   // decoder backs up into its input while the sender keeps offering bytes.
   initial begin
      wait (hold_go);
      @(posedge clock);
      hold_active = 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      hold_active = 1'b0;
   end

   // Result side: random stall bursts and the long hold-off; no random bursts once the run goes quiet.
   initial begin : rsp_side
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_active) begin
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(0, 4);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one raw byte, maybe after an idle burst, and hold it until it is taken.
   // Valid stays high on return so back-to-back bytes need no lowering in between.
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid   <= 1'b0;
         req_rx_byte <= BYTE_W'($urandom);
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic flush_wire();
      while (wire_q.size() > 0) send_byte(wire_q.pop_front());
   endtask

   // Write one register; valid stays high so a batch of writes runs back to back,
   // and the caller drops it after the last one.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      case (idx)
         CSR_START_CODE:     codes.start_code     = value;
         CSR_END_CODE:       codes.end_code       = value;
         CSR_ESCAPE_CODE:    codes.escape_code    = value;
         CSR_START_ESCAPED:  codes.start_escaped  = value;
         CSR_END_ESCAPED:    codes.end_escaped    = value;
         CSR_ESCAPE_ESCAPED: codes.escape_escaped = value;
         default: ;
      endcase
   endtask

   task automatic load_codes(input cfg_type c);
      csr_write(CSR_START_CODE,     c.start_code);
      csr_write(CSR_END_CODE,       c.end_code);
      csr_write(CSR_ESCAPE_CODE,    c.escape_code);
      csr_write(CSR_START_ESCAPED,  c.start_escaped);
      csr_write(CSR_END_ESCAPED,    c.end_escaped);
      csr_write(CSR_ESCAPE_ESCAPED, c.escape_escaped);
      csr_valid <= 1'b0;
   endtask

   // Drain: drop valid, wait for every predicted byte, then let the decoder go idle.
   task automatic settle();
      req_valid <= 1'b0;
      wait (chk_outstanding == 0);
      repeat (4) @(negedge clock);
   endtask

   // Six distinct codes: an odd stride is invertible mod 256, so no two collide.
   function automatic cfg_type spread_codes();
      cfg_type           c;
      logic [BYTE_W-1:0] stride;
      stride           = BYTE_W'($urandom) | 8'h01;
      c.start_code     = BYTE_W'($urandom);
      c.end_code       = c.start_code + stride;
      c.escape_code    = c.end_code + stride;
      c.start_escaped  = c.escape_code + stride;
      c.end_escaped    = c.start_escaped + stride;
      c.escape_escaped = c.end_escaped + stride;
      return c;
   endfunction

   // Encode and send one frame of len payload bytes. Payload is biased toward the
   // codes so stuffing is exercised. A broken frame gets one fault in the middle:
   // an escape with a random second byte, a restart, or a restart right after an escape.
   task automatic send_frame(input int len, input bit broken);
      logic [BYTE_W-1:0] p;
      wire_q.push_back(codes.start_code);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: p = codes.start_code;
               1: p = codes.end_code;
               default: p = codes.escape_code;
            endcase
         end else begin
            p = BYTE_W'($urandom);
         end
         if (p == codes.start_code) begin
            wire_q.push_back(codes.escape_code);
            wire_q.push_back(codes.start_escaped);
         end else if (p == codes.escape_code) begin
            wire_q.push_back(codes.escape_code);
            wire_q.push_back(codes.escape_escaped);
         end else if (p == codes.end_code) begin
            wire_q.push_back(codes.escape_code);
            wire_q.push_back(codes.end_escaped);
         end else begin
            wire_q.push_back(p);
         end
         if (broken && i == len / 2) begin
            case ($urandom_range(0, 2))
               0: begin
                  wire_q.push_back(codes.escape_code);
                  wire_q.push_back(BYTE_W'($urandom));
               end
               1: wire_q.push_back(codes.start_code);
               default: begin
                  wire_q.push_back(codes.escape_code);
                  wire_q.push_back(codes.start_code);
               end
            endcase
         end
      end
      wire_q.push_back(codes.end_code);
      framed_items += wire_q.size();
      flush_wire();
   endtask

   // Mostly well-formed frames of small size, some empty, a few at or past the store
   // limit, one in ten broken, and occasional line noise between frames.
   task automatic random_phase(input int target);
      int len;
      int pick;
      framed_items = 0;
      while (framed_items < target) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) wire_q.push_back(BYTE_W'($urandom));
            flush_wire();
         end
         pick = $urandom_range(0, 99);
         if (pick < 10) len = 0;
         else if (pick < 80) len = $urandom_range(1, 8);
         else if (pick < 95) len = $urandom_range(9, MAX_FRAME_DEF - 1);
         else len = $urandom_range(MAX_FRAME_DEF, MAX_FRAME_DEF + 1);
         send_frame(len, $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin : stimulus
      cfg_type           extreme;
      cfg_type           overlap;
      logic [BYTE_W-1:0] opening [24];

      codes = '{start_code: START_CODE_RST, end_code: END_CODE_RST,
                escape_code: ESCAPE_CODE_RST, start_escaped: START_ESCAPED_RST,
                end_escaped: END_ESCAPED_RST, escape_escaped: ESCAPE_ESCAPED_RST};

      // Extreme codes at both ends of the byte range; the start pair byte doubles as
      // the end code, which is legal since end is not taken while an escape is open.
      extreme = '{start_code: 8'h00, end_code: 8'hFF, escape_code: 8'h80,
                  start_escaped: 8'hFF, end_escaped: 8'h7F, escape_escaped: 8'h01};

      // Coinciding codes: start and end pair bytes equal, escape pair byte equal to
      // the end code, so the decision order alone picks the outcome.
      overlap = '{start_code: 8'hFF, end_code: 8'h00, escape_code: 8'h01,
                  start_escaped: 8'h02, end_escaped: 8'h02, escape_escaped: 8'h00};

      // Directed opening with the reset codes:
      //   a byte ignored outside a frame, an empty frame,
      //   every escape pair plus both byte extremes,
      //   a restart in the middle of an escape pair,
      //   an invalid escape pair that aborts, followed by bytes now ignored.
      opening = '{8'hFF, START_CODE_RST, END_CODE_RST,
                  START_CODE_RST, 8'h00, ESCAPE_CODE_RST, START_ESCAPED_RST,
                  ESCAPE_CODE_RST, ESCAPE_ESCAPED_RST, ESCAPE_CODE_RST, END_ESCAPED_RST,
                  8'hFF, END_CODE_RST,
                  START_CODE_RST, 8'h41, ESCAPE_CODE_RST, START_CODE_RST, 8'h42,
                  END_CODE_RST,
                  START_CODE_RST, ESCAPE_CODE_RST, 8'h07, 8'h55, END_CODE_RST};

      // Hold reset, then release it on a falling edge.
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Writes to the undefined indexes must leave the codes alone.
      csr_write(CSR_SPARE_LO, 8'hFF);
      csr_write(CSR_SPARE_HI, 8'h00);
      csr_valid <= 1'b0;
      @(negedge clock);

      foreach (opening[i]) wire_q.push_back(opening[i]);
      flush_wire();
      settle();

      // Reset codes: a frame that exactly fills the store, one that overflows it,
      // then the long hold-off while full frames keep coming.
      send_frame(MAX_FRAME_DEF, 1'b0);
      send_frame(MAX_FRAME_DEF + 1, 1'b0);
      hold_go = 1'b1;
      repeat (2) send_frame(8, 1'b0);
      random_phase(12);
      settle();

      load_codes(extreme);
      random_phase(12);
      settle();

      load_codes(spread_codes());
      random_phase(12);
      settle();

      load_codes(overlap);
      random_phase(12);
      settle();

      // Final stretch: fresh codes, no idling on either side.
      load_codes(spread_codes());
      quiet = 1'b1;
      random_phase(12);

      // Drain everything, then give stray results time to show up.
      req_valid <= 1'b0;
      wait (chk_outstanding == 0);
      repeat (40) @(negedge clock);
      if (chk_failures == 0 && chk_outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/bsfd_pkg.sv
rtl/bsfd_frame_mem.sv
rtl/bsfd_decode.sv
rtl/byte_stuffed_frame_decoder.sv
tb/sv/byte_stuffed_frame_decoder_checker.sv
tb/sv/byte_stuffed_frame_decoder_tb.sv
